@@ hdl/botm_pkg.sv @@
package botm_pkg;

  localparam int MaxTracked = 16;
  localparam int CoordBits  = 12;
  localparam int IdxBits    = $clog2(MaxTracked);
  localparam int CntBits    = $clog2(MaxTracked + 1);
  localparam int ThrBits    = 17;
  localparam int IdBits     = 16;

  localparam logic [0:0] KindLoad  = 1'b0;
  localparam logic [0:0] KindCheck = 1'b1;

  localparam logic [0:0] CfgAreaThr = 1'b0;
  localparam logic [0:0] CfgCentThr = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic                 first_of_set;
    logic [IdBits-1:0]    id;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [CoordBits-1:0] w;
    logic [CoordBits-1:0] h;
  } item_t;

  typedef struct packed {
    logic [IdBits-1:0]    id;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [CoordBits-1:0] w;
    logic [CoordBits-1:0] h;
  } entry_t;

endpackage

@@ hdl/botm_front.sv @@
// Accepts items into a two-deep queue that decouples the port from the matcher.
module botm_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  botm_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_take,
  output botm_pkg::item_t q_item
);

  botm_pkg::item_t mem_r [2];
  logic            wp_r;
  logic            rp_r;
  logic [1:0]      cnt_r;
  logic            push;
  logic            take;

  assign in_full = (cnt_r == 2'd2);
  assign push    = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign take    = q_take && q_valid;
  assign q_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (take) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, take};
    end
  end

endmodule

@@ hdl/botm_back.sv @@
// Runs one queued item: a load writes the table, a check walks the entries,
// each in turn through read, products, cross products and compare.
module botm_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [botm_pkg::ThrBits-1:0] area_thr,
  input  logic [botm_pkg::ThrBits-1:0] cent_thr,
  input  logic                         q_valid,
  output logic                         q_take,
  input  botm_pkg::item_t              q_item,
  output logic                         res_valid,
  input  logic                         res_pop,
  output logic                         res_matched,
  output logic [botm_pkg::IdBits-1:0]  res_id,
  output botm_pkg::entry_t             res_box
);

  localparam int CB = botm_pkg::CoordBits;
  localparam int PW = 2 * CB + 19;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_CROSS, S_DONE} state_t;

  state_t                      state_r;
  logic [botm_pkg::CntBits-1:0] count_r;
  logic [botm_pkg::CntBits-1:0] idx_r;
  botm_pkg::entry_t            table_r [botm_pkg::MaxTracked];
  botm_pkg::entry_t            ent_r;
  botm_pkg::entry_t            det_r;
  logic                        matched_r;
  logic [botm_pkg::IdBits-1:0] mid_r;
  logic                        res_valid_r;

  // Stage 1 registers.
  logic [2*CB-1:0] a1_r, a2_r, a0_r;
  logic [CB:0]     dx_r, dy_r;
  logic [CB-2:0]   mx_r, my_r;
  // Stage 2 registers.
  logic [2*CB+1:0] uni_r;
  logic [PW-1:0]   lhs_r, rhs_r;
  logic [CB+16:0]  cxl_r, cyl_r;
  logic [CB+16:0]  cxr_r, cyr_r;
  logic            mxz_r, myz_r;

  // Combinational geometry from the detected box and the current entry.
  logic [CB:0]   ex_d, ex_t, ey_d, ey_t, lox, hix, loy, hiy, ovx, ovy;
  logic [CB-2:0] hxd, hxt, hyd, hyt;
  logic [CB:0]   cxd, cxt, cyd, cyt;
  logic [16:0]   one_m;
  logic [2*CB+1:0] uni_c;
  logic          hit;

  always_comb begin
    ex_d = {1'b0, det_r.x} + {1'b0, det_r.w};
    ex_t = {1'b0, ent_r.x} + {1'b0, ent_r.w};
    ey_d = {1'b0, det_r.y} + {1'b0, det_r.h};
    ey_t = {1'b0, ent_r.y} + {1'b0, ent_r.h};
    lox  = (det_r.x > ent_r.x) ? {1'b0, det_r.x} : {1'b0, ent_r.x};
    loy  = (det_r.y > ent_r.y) ? {1'b0, det_r.y} : {1'b0, ent_r.y};
    hix  = (ex_d < ex_t) ? ex_d : ex_t;
    hiy  = (ey_d < ey_t) ? ey_d : ey_t;
    ovx  = (hix > lox) ? hix - lox : '0;
    ovy  = (hiy > loy) ? hiy - loy : '0;
    hxd  = det_r.w[CB-1:1];
    hxt  = ent_r.w[CB-1:1];
    hyd  = det_r.h[CB-1:1];
    hyt  = ent_r.h[CB-1:1];
    cxd  = {1'b0, det_r.x} + {2'b0, hxd};
    cxt  = {1'b0, ent_r.x} + {2'b0, hxt};
    cyd  = {1'b0, det_r.y} + {2'b0, hyd};
    cyt  = {1'b0, ent_r.y} + {2'b0, hyt};
    one_m = 17'h10000 - cent_thr;
    uni_c = {2'b0, a1_r} + {2'b0, a2_r} - {2'b0, a0_r};
    hit = (uni_r != '0 && lhs_r > rhs_r)
       || (!cent_thr[16] && !mxz_r && cxl_r < cxr_r)
       || (!cent_thr[16] && !myz_r && cyl_r < cyr_r);
  end

  assign q_take      = (state_r == S_IDLE) && q_valid && !res_valid_r;
  assign res_valid   = res_valid_r;
  assign res_matched = matched_r;
  assign res_id      = mid_r;
  assign res_box     = det_r;

  always_ff @(posedge clk) begin
    if (q_take && q_item.kind == botm_pkg::KindLoad) begin
      if (q_item.first_of_set) begin
        table_r[0] <= {q_item.id, q_item.x, q_item.y, q_item.w, q_item.h};
      end else if (count_r < botm_pkg::CntBits'(botm_pkg::MaxTracked)) begin
        table_r[count_r[botm_pkg::IdxBits-1:0]] <=
          {q_item.id, q_item.x, q_item.y, q_item.w, q_item.h};
      end
    end
    if (state_r == S_READ) begin
      ent_r <= table_r[idx_r[botm_pkg::IdxBits-1:0]];
    end
    if (state_r == S_MUL) begin
      a1_r <= (2*CB)'(det_r.w) * (2*CB)'(det_r.h);
      a2_r <= (2*CB)'(ent_r.w) * (2*CB)'(ent_r.h);
      a0_r <= (2*CB)'(ovx[CB-1:0]) * (2*CB)'(ovy[CB-1:0]);
      dx_r <= (cxd > cxt) ? cxd - cxt : cxt - cxd;
      dy_r <= (cyd > cyt) ? cyd - cyt : cyt - cyd;
      mx_r <= (hxd < hxt) ? hxd : hxt;
      my_r <= (hyd < hyt) ? hyd : hyt;
    end
    if (state_r == S_CROSS) begin
      uni_r <= uni_c;
      lhs_r <= {3'b0, a0_r, 16'b0};
      rhs_r <= PW'(area_thr) * PW'(uni_c);
      cxl_r <= {dx_r, 16'b0};
      cyl_r <= {dy_r, 16'b0};
      cxr_r <= (CB+17)'(one_m) * (CB+17)'(mx_r);
      cyr_r <= (CB+17)'(one_m) * (CB+17)'(my_r);
      mxz_r <= (mx_r == '0);
      myz_r <= (my_r == '0);
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      res_valid_r <= 1'b0;
      matched_r   <= 1'b0;
      mid_r       <= '0;
    end else begin
      if (res_valid_r && res_pop) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_take) begin
            if (q_item.kind == botm_pkg::KindLoad) begin
              if (q_item.first_of_set) begin
                count_r <= botm_pkg::CntBits'(1);
              end else if (count_r < botm_pkg::CntBits'(botm_pkg::MaxTracked)) begin
                count_r <= count_r + botm_pkg::CntBits'(1);
              end
            end else begin
              det_r     <= {q_item.id, q_item.x, q_item.y, q_item.w, q_item.h};
              idx_r     <= '0;
              matched_r <= 1'b0;
              mid_r     <= '0;
              state_r   <= S_READ;
            end
          end
        end
        S_READ: begin
          state_r <= (idx_r < count_r) ? S_MUL : S_DONE;
        end
        S_MUL: begin
          state_r <= S_CROSS;
        end
        S_CROSS: begin
          state_r <= S_DONE;
          // Compare happens on the cycle after the cross products land.
        end
        S_DONE: begin
          if (idx_r < count_r && hit) begin
            matched_r   <= 1'b1;
            mid_r       <= ent_r.id;
            res_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (idx_r < count_r) begin
            idx_r   <= idx_r + botm_pkg::CntBits'(1);
            state_r <= S_READ;
          end else begin
            res_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/box_overlap_track_matcher.sv @@
// Matches detected boxes against up to 16 tracked boxes loaded earlier. A load
// item passes through the queue and writes the table; a check item walks the
// stored entries through the single shared area and centroid multiply datapath
// in the back end, stopping at the first entry that matches. Each check yields
// one result, which must be popped before the next item is processed.
module box_overlap_track_matcher (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic                                 in_kind,
  input  logic                                 in_first_of_set,
  input  logic [botm_pkg::IdBits-1:0]          in_track_id,
  input  logic [botm_pkg::CoordBits-1:0]       in_box_x,
  input  logic [botm_pkg::CoordBits-1:0]       in_box_y,
  input  logic [botm_pkg::CoordBits-1:0]       in_box_width,
  input  logic [botm_pkg::CoordBits-1:0]       in_box_height,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic                                 out_matched,
  output logic [botm_pkg::IdBits-1:0]          out_matched_id,
  output logic [botm_pkg::CoordBits-1:0]       out_x,
  output logic [botm_pkg::CoordBits-1:0]       out_y,
  output logic [botm_pkg::CoordBits-1:0]       out_width,
  output logic [botm_pkg::CoordBits-1:0]       out_height,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [botm_pkg::ThrBits-1:0]         cfg_data
);

  logic [botm_pkg::ThrBits-1:0] area_thr_r, cent_thr_r;
  botm_pkg::item_t  in_item, q_item;
  botm_pkg::entry_t res_box;
  logic             q_valid, q_take, res_valid;

  assign cfg_ready = 1'b1;
  assign in_item = {in_kind, in_first_of_set, in_track_id, in_box_x, in_box_y,
                    in_box_width, in_box_height};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_thr_r <= botm_pkg::ThrBits'(32768);
      cent_thr_r <= botm_pkg::ThrBits'(32768);
    end else if (cfg_valid) begin
      if (cfg_index == botm_pkg::CfgAreaThr) begin
        area_thr_r <= cfg_data;
      end else if (cfg_index == botm_pkg::CfgCentThr) begin
        cent_thr_r <= cfg_data;
      end
    end
  end

  botm_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_item,
    .q_valid, .q_take, .q_item
  );

  botm_back u_back (
    .clk, .rst_n, .area_thr(area_thr_r), .cent_thr(cent_thr_r),
    .q_valid, .q_take, .q_item, .res_valid, .res_pop(out_pop),
    .res_matched(out_matched), .res_id(out_matched_id), .res_box
  );

  assign out_empty  = !res_valid;
  assign out_x      = res_box.x;
  assign out_y      = res_box.y;
  assign out_width  = res_box.w;
  assign out_height = res_box.h;

  a_unmatched_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_matched) |-> (out_matched_id == '0))
    else $error("unmatched result carries an id");

  a_no_take_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("result dropped before pop");

  a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_matched_id))
    else $error("waiting result changed");

endmodule
